>>> rtl/core/km2d_pkg.sv
// Shared types and constants for the 2D k-means block.
// No dependencies.
package km2d_pkg;

  typedef enum logic [2:0] {
    REQ_CLEAR = 3'd0,
    REQ_LOAD  = 3'd1,
    REQ_SETC  = 3'd2,
    REQ_RUN   = 3'd3,
    REQ_READ  = 3'd4
  } req_t;

  localparam logic [0:0] CFG_K_CLUSTERS = 1'b0;
  localparam logic [0:0] CFG_MAX_ITER   = 1'b1;

  localparam int COORD_W = 12;
  localparam int IDX_W   = 12;
  localparam int LAB_W   = 4;
  localparam int ITER_W  = 16;

  // one queued request beat
  typedef struct packed {
    req_t               req;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [IDX_W-1:0]   idx;
  } cmd_t;

endpackage

>>> rtl/core/kmeans_2d_clustering.sv
// Top level of the 2D k-means block: config registers, front queue, back end.
// Depends on km2d_pkg, km2d_front, km2d_back.
// Commands go into a two-beat queue; busy rises only when it is full. Load,
// clear and set-centroid beats are handled in the back end as they are popped.
// A run takes per pass a setup state, then an assignment walk over all points
// (one cluster distance a cycle, between a read and an accumulate state), then
// x and y means of each non-empty cluster from the shared bit-serial divider
// (W = 25 bits at the default sizes), empty clusters skipped, then K report
// beats, one a cycle. Results appear for a single cycle on out_valid and
// cannot be held off.
module kmeans_2d_clustering #(
  parameter int MAX_POINTS   = 4096,
  parameter int MAX_CLUSTERS = 16,
  parameter int COORD_BITS   = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [11:0] in_coord_x,
  input  logic [11:0] in_coord_y,
  input  logic [11:0] in_item_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic        out_kind,
  output logic [11:0] out_index,
  output logic [11:0] out_cent_x,
  output logic [11:0] out_cent_y,
  output logic [3:0]  out_point_cluster,
  output logic [15:0] out_iterations_done,
  output logic        out_converged,
  output logic        out_last
);

  logic [4:0]  k_r;
  logic [15:0] iter_r;
  logic           q_valid, pop;
  km2d_pkg::cmd_t q_head;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= 5'd2;
      iter_r <= 16'd1000;
    end else if (cfg_valid) begin
      if (cfg_index == km2d_pkg::CFG_K_CLUSTERS) k_r <= cfg_data[4:0];
      else iter_r <= cfg_data;
    end
  end

  km2d_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_req_type(in_req_type),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_item_index(in_item_index), .busy(busy), .pop(pop),
    .q_valid(q_valid), .q_head(q_head)
  );

  km2d_back #(
    .MAX_POINTS(MAX_POINTS), .MAX_CLUSTERS(MAX_CLUSTERS), .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head), .pop(pop),
    .k_cfg(k_r), .iter_cfg(iter_r), .out_valid(out_valid), .out_kind(out_kind),
    .out_index(out_index), .out_cent_x(out_cent_x), .out_cent_y(out_cent_y),
    .out_point_cluster(out_point_cluster),
    .out_iterations_done(out_iterations_done),
    .out_converged(out_converged), .out_last(out_last)
  );

endmodule

>>> rtl/core/km2d_front.sv
// Front end: takes command beats, drops unknown codes, feeds a short queue.
// Depends on km2d_pkg.
module km2d_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [2:0]       in_req_type,
  input  logic [11:0]      in_coord_x,
  input  logic [11:0]      in_coord_y,
  input  logic [11:0]      in_item_index,
  output logic             busy,
  input  logic             pop,
  output logic             q_valid,
  output km2d_pkg::cmd_t   q_head
);

  km2d_pkg::cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, known;

  assign busy    = (cnt_r == 2'd2);
  assign known   = (in_req_type <= 3'd4);
  assign push    = start && !busy && known;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = mem_r[rp_r];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{req: km2d_pkg::req_t'(in_req_type), x: in_coord_x,
                       y: in_coord_y, idx: in_item_index};
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/core/km2d_div.sv
// Restoring divider, one quotient bit a cycle.
// No dependencies.
module km2d_div #(
  parameter int NW = 32,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] n_r;
  logic          run_r;
  logic [DW:0]   sh;

  assign sh   = {rem_r[DW-1:0], q_r[NW-1]};
  assign quo  = q_r;
  assign done = run_r && (n_r == CW'(0));

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= num;
      rem_r <= '0;
      d_r   <= den;
    end else if (run_r && n_r != CW'(0)) begin
      if (sh >= {1'b0, d_r}) begin
        rem_r <= sh - {1'b0, d_r};
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= sh;
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
    end
    if (!rst_n) begin
      run_r <= 1'b0;
      n_r   <= '0;
    end else if (go) begin
      run_r <= 1'b1;
      n_r   <= CW'(NW);
    end else if (run_r) begin
      if (n_r == CW'(0)) run_r <= 1'b0;
      else n_r <= n_r - CW'(1);
    end
  end

endmodule

>>> rtl/core/km2d_back.sv
// Back end: point store, centroids, Lloyd passes and reports.
// Depends on km2d_pkg and km2d_div.
module km2d_back #(
  parameter int MAX_POINTS   = 4096,
  parameter int MAX_CLUSTERS = 16,
  parameter int COORD_BITS   = 12
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  km2d_pkg::cmd_t q_head,
  output logic           pop,
  input  logic [4:0]     k_cfg,
  input  logic [15:0]    iter_cfg,
  output logic           out_valid,
  output logic           out_kind,
  output logic [11:0]    out_index,
  output logic [11:0]    out_cent_x,
  output logic [11:0]    out_cent_y,
  output logic [3:0]     out_point_cluster,
  output logic [15:0]    out_iterations_done,
  output logic           out_converged,
  output logic           out_last
);

  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW = $clog2(MAX_CLUSTERS + 1);
  localparam int SW = COORD_BITS + NW;
  localparam int DW = 2 * COORD_BITS + 2;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CLR   = 10'b0000000010,
    S_RD    = 10'b0000000100,
    S_SCAN  = 10'b0000001000,
    S_ACC   = 10'b0000010000,
    S_DIVGO = 10'b0000100000,
    S_DIVX  = 10'b0001000000,
    S_DIVY  = 10'b0010000000,
    S_EMIT  = 10'b0100000000,
    S_LAB   = 10'b1000000000
  } state_t;

  state_t state_r;

  logic [COORD_BITS-1:0]       px_mem [MAX_POINTS];
  logic [COORD_BITS-1:0]       py_mem [MAX_POINTS];
  logic [km2d_pkg::LAB_W-1:0]  lab_mem [MAX_POINTS];

  logic [COORD_BITS-1:0] cx_r [MAX_CLUSTERS];
  logic [COORD_BITS-1:0] cy_r [MAX_CLUSTERS];
  logic [SW-1:0]         sx_r [MAX_CLUSTERS];
  logic [SW-1:0]         sy_r [MAX_CLUSTERS];
  logic [NW-1:0]         mc_r [MAX_CLUSTERS];

  logic [NW-1:0]  pcount_r;
  logic [PW-1:0]  p_r;
  logic [CW-1:0]  c_r, best_r;
  logic [KW-1:0]  k_r;
  logic [15:0]    lim_r, pass_r;
  logic           moved_r, conv_r;
  logic [DW-1:0]  best_d_r;
  logic [COORD_BITS-1:0] rx_r, ry_r, nx_r;
  logic [km2d_pkg::LAB_W-1:0] rl_r;
  logic           rd_ok_r;
  logic [11:0]    ridx_r;

  // squared distance of current point to cluster c_r
  logic signed [COORD_BITS:0] dx, dy;
  logic [DW-1:0] dist_sq;
  logic [CW-1:0] cur_c;
  assign cur_c = c_r;
  assign dx = $signed({1'b0, rx_r}) - $signed({1'b0, cx_r[cur_c]});
  assign dy = $signed({1'b0, ry_r}) - $signed({1'b0, cy_r[cur_c]});
  assign dist_sq = DW'(dx * dx) + DW'(dy * dy);

  logic div_go, div_done;
  logic [SW-1:0] div_num, div_q;
  km2d_div #(.NW(SW), .DW(NW)) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num),
    .den(mc_r[c_r]), .done(div_done), .quo(div_q)
  );
  // x sum goes in from S_DIVGO, y sum from the end of S_DIVX
  assign div_num = (state_r == S_DIVX) ? sy_r[c_r] : sx_r[c_r];
  assign div_go  = (state_r == S_DIVGO) || (state_r == S_DIVX && div_done);

  // current cluster's new mean differs from its centroid
  logic cur_mv;
  assign cur_mv = (nx_r != cx_r[c_r]) || (div_q[COORD_BITS-1:0] != cy_r[c_r]);

  logic last_c, last_p;
  assign last_c = (KW'(c_r) == k_r - KW'(1));
  assign last_p = (NW'(p_r) == pcount_r - NW'(1));

  assign pop = q_valid && (state_r == S_IDLE);

  // command intake
  logic [KW-1:0] k_eff;
  always_comb begin
    if (k_cfg == 5'd0) k_eff = KW'(1);
    else if (32'(k_cfg) > MAX_CLUSTERS) k_eff = KW'(MAX_CLUSTERS);
    else k_eff = KW'(k_cfg);
  end

  // point store
  always_ff @(posedge clk) begin
    if (pop && q_head.req == km2d_pkg::REQ_LOAD && 32'(pcount_r) < MAX_POINTS) begin
      px_mem[pcount_r[PW-1:0]] <= q_head.x[COORD_BITS-1:0];
      py_mem[pcount_r[PW-1:0]] <= q_head.y[COORD_BITS-1:0];
    end
    rx_r <= px_mem[p_r];
    ry_r <= py_mem[p_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ACC) lab_mem[p_r] <= km2d_pkg::LAB_W'(best_r);
    rl_r <= lab_mem[q_head.idx[PW-1:0]];
  end

  // result strobe, one cycle per report beat
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= (state_r == S_EMIT) || (state_r == S_LAB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pcount_r <= '0;
      k_r      <= KW'(1);
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cx_r[i] <= '0;
        cy_r[i] <= '0;
        sx_r[i] <= '0;
        sy_r[i] <= '0;
        mc_r[i] <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            case (q_head.req)
              km2d_pkg::REQ_CLEAR: pcount_r <= '0;
              km2d_pkg::REQ_LOAD:
                if (32'(pcount_r) < MAX_POINTS) pcount_r <= pcount_r + NW'(1);
              km2d_pkg::REQ_SETC:
                if (32'(q_head.idx) < MAX_CLUSTERS) begin
                  cx_r[q_head.idx[CW-1:0]] <= q_head.x[COORD_BITS-1:0];
                  cy_r[q_head.idx[CW-1:0]] <= q_head.y[COORD_BITS-1:0];
                end
              km2d_pkg::REQ_RUN: begin
                k_r    <= k_eff;
                lim_r  <= (iter_cfg == 16'd0) ? 16'd1 : iter_cfg;
                pass_r <= '0;
                state_r <= S_CLR;
              end
              km2d_pkg::REQ_READ: begin
                ridx_r  <= q_head.idx;
                rd_ok_r <= (32'(q_head.idx) < 32'(pcount_r));
                state_r <= S_LAB;
              end
              default: ;
            endcase
          end
        end
        // clear sums, start a pass
        S_CLR: begin
          for (int i = 0; i < MAX_CLUSTERS; i++) begin
            sx_r[i] <= '0;
            sy_r[i] <= '0;
            mc_r[i] <= '0;
          end
          p_r     <= '0;
          moved_r <= 1'b0;
          pass_r  <= pass_r + 16'd1;
          state_r <= (pcount_r == '0) ? S_DIVGO : S_RD;
          c_r     <= '0;
        end
        S_RD: begin
          c_r      <= '0;
          best_r   <= '0;
          best_d_r <= '1;
          state_r  <= S_SCAN;
        end
        // one cluster a cycle
        S_SCAN: begin
          if (dist_sq <= best_d_r) begin
            best_d_r <= dist_sq;
            best_r   <= c_r;
          end
          if (last_c) state_r <= S_ACC;
          else c_r <= c_r + CW'(1);
        end
        S_ACC: begin
          sx_r[best_r] <= sx_r[best_r] + SW'(rx_r);
          sy_r[best_r] <= sy_r[best_r] + SW'(ry_r);
          mc_r[best_r] <= mc_r[best_r] + NW'(1);
          if (last_p) begin
            c_r <= '0;
            state_r <= S_DIVGO;
          end else begin
            p_r <= p_r + PW'(1);
            state_r <= S_RD;
          end
        end
        // update centroids one by one
        S_DIVGO: begin
          if (mc_r[c_r] == '0) begin
            if (last_c) begin
              c_r <= '0;
              if (!moved_r || pass_r >= lim_r) begin
                conv_r <= !moved_r;
                state_r <= S_EMIT;
              end else state_r <= S_CLR;
            end else c_r <= c_r + CW'(1);
          end else state_r <= S_DIVX;
        end
        S_DIVX: if (div_done) begin
          nx_r <= div_q[COORD_BITS-1:0];
          state_r <= S_DIVY;
        end
        S_DIVY: if (div_done) begin
          if (cur_mv) moved_r <= 1'b1;
          cx_r[c_r] <= nx_r;
          cy_r[c_r] <= div_q[COORD_BITS-1:0];
          if (last_c) begin
            c_r <= '0;
            if (!cur_mv && !moved_r) begin
              conv_r <= 1'b1;
              state_r <= S_EMIT;
            end else if (pass_r >= lim_r) begin
              conv_r <= 1'b0;
              state_r <= S_EMIT;
            end else state_r <= S_CLR;
          end else begin
            c_r <= c_r + CW'(1);
            state_r <= S_DIVGO;
          end
        end
        S_EMIT: begin
          out_kind  <= 1'b0;
          out_index <= 12'(c_r);
          out_cent_x <= 12'(cx_r[c_r]);
          out_cent_y <= 12'(cy_r[c_r]);
          out_point_cluster <= '0;
          out_iterations_done <= pass_r;
          out_converged <= conv_r;
          out_last <= last_c;
          if (last_c) state_r <= S_IDLE;
          else c_r <= c_r + CW'(1);
        end
        S_LAB: begin
          out_kind  <= 1'b1;
          out_index <= ridx_r;
          out_cent_x <= '0;
          out_cent_y <= '0;
          out_point_cluster <= rd_ok_r ? rl_r : 4'd0;
          out_iterations_done <= '0;
          out_converged <= 1'b0;
          out_last <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
